/* src/slbc_pkg.sv */
// Shared types and constants for the status LED blink controller.
// No dependencies; used by every module in src.
package slbc_pkg;

    localparam int NUM_PINS      = 16;
    localparam int PERIOD_W      = 16;
    localparam int COUNT_W       = 5;
    localparam int OP_W          = 3;
    localparam int INDEX_W       = 4;
    localparam int STATE_W       = 3;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 24;
    localparam int CFG_INDEX_W   = 2;

    localparam int DEF_MAX_CHANNELS  = 16;
    localparam int DEF_BASE_CHANNELS = 4;

    localparam logic [PERIOD_W-1:0] RST_SHORT_PERIOD   = 16'd250;
    localparam logic [PERIOD_W-1:0] RST_BREAK_PERIOD   = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_UNKNOWN_PERIOD = 16'd1000;
    localparam logic [COUNT_W-1:0]  RST_ACTIVE_COUNT   = 5'd4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 3'd0,
        OP_SET_STATE    = 3'd1,
        OP_SET_LED      = 3'd2,
        OP_AUTO_ENABLE  = 3'd3,
        OP_AUTO_DISABLE = 3'd4
    } t_op;

    typedef enum logic [STATE_W-1:0] {
        ST_NORMAL  = 3'd0,
        ST_ALARM   = 3'd1,
        ST_SHORT   = 3'd2,
        ST_BREAK   = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_led_state;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHORT_PERIOD   = 2'd0,
        CFG_BREAK_PERIOD   = 2'd1,
        CFG_UNKNOWN_PERIOD = 2'd2,
        CFG_ACTIVE_COUNT   = 2'd3
    } t_cfg_index;

    // blink phase bits, one per blinking pattern
    typedef struct packed {
        logic unknown_ph;
        logic break_ph;
        logic short_ph;
    } t_phases;

endpackage

/* src/slbc_blink.sv */
// One blink pattern timer: saturating tick counter and phase toggle.
// Depends on slbc_pkg.
module slbc_blink (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic [slbc_pkg::PERIOD_W-1:0] i_period,
    output logic                          o_phase_next
);

    logic [slbc_pkg::PERIOD_W-1:0] r_count, n_count, w_inc;
    logic                          r_phase, n_phase;

    always_comb begin
        w_inc   = (r_count != '1) ? r_count + 1'b1 : r_count;
        n_count = r_count;
        n_phase = r_phase;
        if (i_tick) begin
            if (w_inc >= i_period) begin
                n_count = '0;
                n_phase = ~r_phase;
            end else begin
                n_count = w_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= 1'b0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    assign o_phase_next = n_phase;

endmodule

/* src/slbc_drive.sv */
// Pin level map: channel states or manual mask to active-low/high pin levels.
// Depends on slbc_pkg.
module slbc_drive #(
    parameter int NUM_LEDS      = slbc_pkg::DEF_MAX_CHANNELS,
    parameter int BASE_CHANNELS = slbc_pkg::DEF_BASE_CHANNELS
) (
    input  logic                                   i_auto,
    input  logic [slbc_pkg::NUM_PINS-1:0]          i_mask,
    input  logic [NUM_LEDS*slbc_pkg::STATE_W-1:0]  i_states,
    input  slbc_pkg::t_phases                      i_phases,
    input  logic [6:0]                             i_limit,
    output logic [slbc_pkg::NUM_PINS-1:0]          o_drive
);

    for (genvar g = 0; g < slbc_pkg::NUM_PINS; g++) begin : g_pin
        if (g < NUM_LEDS) begin : g_live
            logic [slbc_pkg::STATE_W-1:0] w_st;
            logic                         w_auto_on;
            logic                         w_on;
            assign w_st = i_states[g*slbc_pkg::STATE_W +: slbc_pkg::STATE_W];
            always_comb begin
                case (w_st)
                    slbc_pkg::ST_ALARM:   w_auto_on = 1'b1;
                    slbc_pkg::ST_SHORT:   w_auto_on = i_phases.short_ph;
                    slbc_pkg::ST_BREAK:   w_auto_on = i_phases.break_ph;
                    slbc_pkg::ST_UNKNOWN: w_auto_on = i_phases.unknown_ph;
                    default:              w_auto_on = 1'b0;
                endcase
            end
            assign w_on = (7'(g) < i_limit) && (i_auto ? w_auto_on : i_mask[g]);
            // base channels are wired active-low
            if (g < BASE_CHANNELS) begin : g_inv
                assign o_drive[g] = ~w_on;
            end else begin : g_norm
                assign o_drive[g] = w_on;
            end
        end else begin : g_absent
            // pins beyond the channel count are driven low
            assign o_drive[g] = 1'b0;
        end
    end

endmodule

/* src/status_led_blink_controller.sv */
// Top level of the status LED blink controller: command register, state,
// result register. Depends on slbc_pkg, slbc_blink, slbc_drive.
//
// Usage:
//   Commands enter on the slave stream (i_s_*), one request per accepted
//   beat: tick, set channel state, manual set LED, enable or disable auto.
//   Every request gives exactly one result on the master stream (o_m_*):
//   the 16 pin levels after the request and an accepted flag.
//   The command is captured in an input register, then processed and its
//   result is registered in the output register, which drives o_m_tvalid.
//   One request per cycle is sustained while the receiver keeps i_m_tready
//   high; all channels and the three blink timers update in parallel.
//   When the receiver holds i_m_tready low, the result waits in the output
//   register and one more request may sit in the input register; after
//   that o_s_tready drops until the result is taken.
//   Registers (periods, active count) are written on the cfg channel,
//   which is always ready; write them only while no request is in flight.
//   Reset: periods 250/500/1000, active count 4, all channels unknown,
//   auto mode on, manual mask clear, blink counters and phases zero.
module status_led_blink_controller #(
    parameter int MAX_CHANNELS  = slbc_pkg::DEF_MAX_CHANNELS,
    parameter int BASE_CHANNELS = slbc_pkg::DEF_BASE_CHANNELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream; tdata: op[2:0], led_index[6:3], led_state[9:7], led_on[10]
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [slbc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // master stream; tdata: led_drive[15:0], accepted[16]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [slbc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slbc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [slbc_pkg::PERIOD_W-1:0]       i_cfg_data
);

    localparam int NUM_LEDS = (MAX_CHANNELS < slbc_pkg::NUM_PINS) ?
                              MAX_CHANNELS : slbc_pkg::NUM_PINS;
    localparam int SW = slbc_pkg::STATE_W;

    // config registers
    logic [slbc_pkg::PERIOD_W-1:0] r_short_period, r_break_period, r_unknown_period;
    logic [slbc_pkg::COUNT_W-1:0]  r_active_count;

    // input register
    logic                             r_in_valid;
    logic [slbc_pkg::OP_W-1:0]        r_op;
    logic [slbc_pkg::INDEX_W-1:0]     r_idx;
    logic [SW-1:0]                    r_st;
    logic                             r_on;

    // block state
    logic [NUM_LEDS*SW-1:0]           r_states, n_states;
    logic                             r_auto, n_auto;
    logic [slbc_pkg::NUM_PINS-1:0]    r_mask, n_mask;

    // output register
    logic                             r_out_valid;
    logic [slbc_pkg::NUM_PINS-1:0]    r_drive;
    logic                             r_ok, n_ok;

    logic                             w_fire, w_s_accept, w_present, w_tick;
    logic [6:0]                       w_limit;
    logic                             w_short_ph, w_break_ph, w_unknown_ph;
    slbc_pkg::t_phases                w_ph_next;
    logic [slbc_pkg::NUM_PINS-1:0]    w_drive;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_period   <= slbc_pkg::RST_SHORT_PERIOD;
            r_break_period   <= slbc_pkg::RST_BREAK_PERIOD;
            r_unknown_period <= slbc_pkg::RST_UNKNOWN_PERIOD;
            r_active_count   <= slbc_pkg::RST_ACTIVE_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slbc_pkg::CFG_SHORT_PERIOD:   r_short_period   <= i_cfg_data;
                slbc_pkg::CFG_BREAK_PERIOD:   r_break_period   <= i_cfg_data;
                slbc_pkg::CFG_UNKNOWN_PERIOD: r_unknown_period <= i_cfg_data;
                slbc_pkg::CFG_ACTIVE_COUNT:
                    r_active_count <= i_cfg_data[slbc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: stage 1 moves on when the result register is empty or being taken
    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_op  <= i_s_tdata[2:0];
            r_idx <= i_s_tdata[6:3];
            r_st  <= i_s_tdata[9:7];
            r_on  <= i_s_tdata[10];
        end
    end

    // channels present: below active count, clamped to MAX_CHANNELS
    assign w_limit   = ({2'b00, r_active_count} > 7'(MAX_CHANNELS)) ?
                       7'(MAX_CHANNELS) : {2'b00, r_active_count};
    assign w_present = {3'b000, r_idx} < w_limit;
    assign w_tick    = w_fire && (r_op == slbc_pkg::OP_TICK);

    always_comb begin
        n_states = r_states;
        n_auto   = r_auto;
        n_mask   = r_mask;
        n_ok     = 1'b0;
        case (r_op)
            slbc_pkg::OP_TICK: n_ok = 1'b1;
            slbc_pkg::OP_SET_STATE: begin
                if (w_present && (r_st <= slbc_pkg::ST_UNKNOWN)) begin
                    n_ok = 1'b1;
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        if (r_idx == slbc_pkg::INDEX_W'(i)) begin
                            n_states[i*SW +: SW] = r_st;
                        end
                    end
                end
            end
            slbc_pkg::OP_SET_LED: begin
                if (!r_auto && w_present) begin
                    n_ok = 1'b1;
                    for (int i = 0; i < slbc_pkg::NUM_PINS; i++) begin
                        if (r_idx == slbc_pkg::INDEX_W'(i)) begin
                            n_mask[i] = r_on;
                        end
                    end
                end
            end
            slbc_pkg::OP_AUTO_ENABLE: begin
                if (!r_auto) begin
                    n_auto = 1'b1;
                    n_ok   = 1'b1;
                end
            end
            slbc_pkg::OP_AUTO_DISABLE: begin
                if (r_auto) begin
                    n_auto = 1'b0;
                    n_mask = '0;
                    n_ok   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_states[i*SW +: SW] <= slbc_pkg::ST_UNKNOWN;
            end
            r_auto <= 1'b1;
            r_mask <= '0;
        end else if (w_fire) begin
            r_states <= n_states;
            r_auto   <= n_auto;
            r_mask   <= n_mask;
        end
    end

    slbc_blink u_blink_short (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_period     (r_short_period),
        .o_phase_next (w_short_ph)
    );

    slbc_blink u_blink_break (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_period     (r_break_period),
        .o_phase_next (w_break_ph)
    );

    slbc_blink u_blink_unknown (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_period     (r_unknown_period),
        .o_phase_next (w_unknown_ph)
    );

    assign w_ph_next = {w_unknown_ph, w_break_ph, w_short_ph};

    // pins reflect the state after this request
    slbc_drive #(
        .NUM_LEDS      (NUM_LEDS),
        .BASE_CHANNELS (BASE_CHANNELS)
    ) u_drive (
        .i_auto   (n_auto),
        .i_mask   (n_mask),
        .i_states (n_states),
        .i_phases (w_ph_next),
        .i_limit  (w_limit),
        .o_drive  (w_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_drive <= w_drive;
            r_ok    <= n_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_ok, r_drive};

endmodule
